@@ design/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and helpers of the perspective point transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int NUM_ENTRIES   = 2 * NUM_REGS;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_SEL_W     = $clog2(NUM_REGS);
    localparam int CFG_DATA_W    = 64;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int PSUM_W        = PROD_W + 2;
    localparam int QUO_W         = COORD_W + 1;
    localparam int FRONT_STAGES  = 4;
    localparam int FCNT_W        = $clog2(FRONT_STAGES + 1);
    localparam int QUEUE_DEPTH   = 8;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        WC_ZERO,
        WC_ONE,
        WC_DIV
    } t_wclass;

    typedef logic [NUM_ENTRIES-1:0][COORD_W-1:0] t_matrix;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_status;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               sat;
    } t_lane_res;

    // identity matrix, entry 1.0 written as 65536 regardless of fraction width
    function automatic logic [CFG_DATA_W-1:0] cfg_reset_val(input int idx);
        logic [CFG_DATA_W-1:0] v;
        v = '0;
        if (idx == 0 || idx == 5) begin
            v = CFG_DATA_W'(65536);
        end else if (idx == 2 || idx == 7) begin
            v = CFG_DATA_W'(65536) << COORD_W;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/tpc_if.sv @@
// ----------------------------------------------------------------------------
// tpc_if
// Channel interfaces: point input, result output and register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpc_pt_if import tpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface tpc_res_if import tpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      w_was_zero;
    logic                      saturated;
    modport source (output valid, out_x, out_y, out_z, w_was_zero, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, w_was_zero, saturated, output ready);
endinterface

interface tpc_cfg_if import tpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/tpc_front.sv @@
// ----------------------------------------------------------------------------
// tpc_front
// Multiply-accumulate pipeline: four column sums, then w classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_front import tpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic signed [COORD_W-1:0]             i_x,
    input  wire logic signed [COORD_W-1:0]             i_y,
    input  wire logic signed [COORD_W-1:0]             i_z,
    input  wire t_matrix                               i_mat,
    output logic                                       o_valid,
    output t_wclass                                    o_cls,
    output logic [3:0]                                 o_neg,
    output logic [3:0][PSUM_W-FRAC_BITS:0]             o_mag,
    output logic [FCNT_W-1:0]                          o_inflight
);

    localparam int S_W = PSUM_W - FRAC_BITS + 1;

    logic signed [COORD_W-1:0] w_pt [3];

    logic                       r_va, r_vb, r_vc, r_vd;
    logic signed [PROD_W-1:0]   r_prod [4][3];
    logic signed [PSUM_W-1:0]   r_sum  [4];
    logic signed [S_W-1:0]      r_s    [4];
    t_wclass                    r_cls, n_cls;
    logic [3:0]                 r_neg, n_neg;
    logic [3:0][S_W-1:0]        r_mag, n_mag;

    assign w_pt[0] = i_x;
    assign w_pt[1] = i_y;
    assign w_pt[2] = i_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
        for (int j = 0; j < 4; j++) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[j][r] <= w_pt[r] * $signed(i_mat[4*r+j]);
            end
            r_sum[j] <= PSUM_W'(r_prod[j][0]) + PSUM_W'(r_prod[j][1])
                      + PSUM_W'(r_prod[j][2]);
            // floor shift, then translation in point scale
            r_s[j]   <= S_W'(r_sum[j] >>> FRAC_BITS) + S_W'($signed(i_mat[12+j]));
        end
        r_cls <= n_cls;
        r_neg <= n_neg;
        r_mag <= n_mag;
    end

    always_comb begin
        if (r_s[3] == '0) begin
            n_cls = WC_ZERO;
        end else if (r_s[3] == (S_W'(1) << FRAC_BITS)) begin
            n_cls = WC_ONE;
        end else begin
            n_cls = WC_DIV;
        end
        for (int j = 0; j < 4; j++) begin
            n_neg[j] = r_s[j][S_W-1];
            n_mag[j] = n_neg[j] ? S_W'(-r_s[j]) : S_W'(r_s[j]);
        end
    end

    assign o_valid    = r_vd;
    assign o_cls      = r_cls;
    assign o_neg      = r_neg;
    assign o_mag      = r_mag;
    assign o_inflight = FCNT_W'(r_va) + FCNT_W'(r_vb) + FCNT_W'(r_vc) + FCNT_W'(r_vd);

endmodule

`default_nettype wire

@@ design/tpc_queue.sv @@
// ----------------------------------------------------------------------------
// tpc_queue
// Small register fifo between the sum pipeline and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_queue import tpc_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output t_q_status              o_status
);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

@@ design/tpc_back.sv @@
// ----------------------------------------------------------------------------
// tpc_back
// Pipelined restoring divide by w, one quotient bit per stage, saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_back import tpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire t_wclass                       i_cls,
    input  wire logic [3:0]                    i_neg,
    input  wire logic [3:0][PSUM_W-FRAC_BITS:0] i_mag,
    output logic                               o_pop,
    tpc_res_if.source                          o_res
);

    localparam int S_W   = PSUM_W - FRAC_BITS + 1;
    localparam int NUM_W = S_W + FRAC_BITS;
    localparam int CMP_W = S_W + QUO_W;
    localparam int NSTG  = QUO_W;

    function automatic t_lane_res sat_lane(input logic neg, input logic big,
                                           input logic [QUO_W-1:0] q);
        t_lane_res res;
        res.sat = 1'b0;
        res.val = q[COORD_W-1:0];
        if (big) begin
            res.sat = 1'b1;
            res.val = neg ? COORD_MIN : COORD_MAX;
        end else if (neg) begin
            if (q > QUO_W'(COORD_MIN)) begin
                res.sat = 1'b1;
                res.val = COORD_MIN;
            end else begin
                res.val = COORD_W'(-q);
            end
        end else if (q > QUO_W'(COORD_MAX)) begin
            res.sat = 1'b1;
            res.val = COORD_MAX;
        end
        return res;
    endfunction

    logic             en;
    logic             r_v    [NSTG+1];
    t_wclass          r_cls  [NSTG+1];
    logic [S_W-1:0]   r_dmag [NSTG+1];
    logic [NUM_W-1:0] r_rem  [NSTG+1][3];
    logic [QUO_W-1:0] r_q    [NSTG+1][3];
    logic             r_big  [NSTG+1][3];
    logic             r_sgn  [NSTG+1][3];

    logic [NUM_W-1:0] n_rem [3];
    logic [QUO_W-1:0] n_q   [3];
    logic             n_big [3];
    logic             n_sgn [3];

    logic             r_ovld;
    logic [COORD_W-1:0] r_ox, r_oy, r_oz;
    logic             r_owz, r_osat;
    t_lane_res        lane_res [3];

    // whole pipeline moves while the output register is free or being taken
    assign en    = !r_ovld || o_res.ready;
    assign o_pop = en && i_valid;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_rem[l] = NUM_W'(i_mag[l]) << FRAC_BITS;
            if (i_cls == WC_DIV) begin
                n_sgn[l] = i_neg[l] ^ i_neg[3];
                // quotient would need more than QUO_W bits
                n_big[l] = CMP_W'(n_rem[l]) >= (CMP_W'(i_mag[3]) << QUO_W);
                n_q[l]   = '0;
            end else begin
                n_sgn[l] = i_neg[l];
                n_big[l] = |i_mag[l][S_W-1:QUO_W];
                n_q[l]   = i_mag[l][QUO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
        end
        if (en) begin
            r_cls[0]  <= i_cls;
            r_dmag[0] <= i_mag[3];
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= n_rem[l];
                r_q[0][l]   <= n_q[l];
                r_big[0][l] <= n_big[l];
                r_sgn[0][l] <= n_sgn[l];
            end
        end
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_div
        localparam int B = NSTG - 1 - k;
        logic [CMP_W-1:0] trial;
        logic [NUM_W-1:0] rem_nx [3];
        logic [QUO_W-1:0] q_nx   [3];

        assign trial = CMP_W'(r_dmag[k]) << B;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                rem_nx[l] = r_rem[k][l];
                q_nx[l]   = r_q[k][l];
                if (r_cls[k] == WC_DIV && !r_big[k][l]
                    && CMP_W'(r_rem[k][l]) >= trial) begin
                    rem_nx[l]  = NUM_W'(CMP_W'(r_rem[k][l]) - trial);
                    q_nx[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
            if (en) begin
                r_cls[k+1]  <= r_cls[k];
                r_dmag[k+1] <= r_dmag[k];
                for (int l = 0; l < 3; l++) begin
                    r_rem[k+1][l] <= rem_nx[l];
                    r_q[k+1][l]   <= q_nx[l];
                    r_big[k+1][l] <= r_big[k][l];
                    r_sgn[k+1][l] <= r_sgn[k][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            lane_res[l] = sat_lane(r_sgn[NSTG][l], r_big[NSTG][l], r_q[NSTG][l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_v[NSTG];
        end
        if (en) begin
            if (r_cls[NSTG] == WC_ZERO) begin
                r_ox   <= '0;
                r_oy   <= '0;
                r_oz   <= '0;
                r_owz  <= 1'b1;
                r_osat <= 1'b0;
            end else begin
                r_ox   <= lane_res[0].val;
                r_oy   <= lane_res[1].val;
                r_oz   <= lane_res[2].val;
                r_owz  <= 1'b0;
                r_osat <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
            end
        end
    end

    assign o_res.valid      = r_ovld;
    assign o_res.out_x      = r_ox;
    assign o_res.out_y      = r_oy;
    assign o_res.out_z      = r_oz;
    assign o_res.w_was_zero = r_owz;
    assign o_res.saturated  = r_osat;

endmodule

`default_nettype wire

@@ design/vec3_transform_perspective_core.sv @@
// ----------------------------------------------------------------------------
// vec3_transform_perspective_core
// 4x4 homogeneous point transform in fixed point with divide by w.
//
//   channel | dir | beat contents
//   i_pt    | in  | in_x, in_y, in_z
//   o_res   | out | out_x, out_y, out_z, w_was_zero, saturated
//   i_cfg   | in  | index, data (one matrix register of two entries)
//
// One point per cycle sustained while o_res takes results and the queue has room;
// a point passes through the multiply-accumulate front, the queue, the divider load
// register, a divider stage per quotient bit (QUO_W), and the output register.
// Input ready follows the free queue slots not yet claimed by the front.
// A stall at o_res freezes the divider only; the front keeps filling the queue.
// Reset is synchronous and loads the identity matrix when FRAC_BITS is 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vec3_transform_perspective_core import tpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpc_pt_if.sink     i_pt,
    tpc_res_if.source  o_res,
    tpc_cfg_if.sink    i_cfg
);

    localparam int S_W    = PSUM_W - FRAC_BITS + 1;
    localparam int ENTRY_W = 2 + 4 + 4 * S_W;

    logic [CFG_DATA_W-1:0] r_cfg [NUM_REGS];
    t_matrix               mat;

    logic                  f_valid;
    t_wclass               f_cls;
    logic [3:0]            f_neg;
    logic [3:0][S_W-1:0]   f_mag;
    logic [FCNT_W-1:0]     f_inflight;

    logic [ENTRY_W-1:0]    q_in, q_out;
    t_q_status             q_stat;
    logic                  pop;
    logic [3:0][S_W-1:0]   b_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= cfg_reset_val(i);
            end
        end else if (i_cfg.valid && i_cfg.index < CFG_IDX_W'(NUM_REGS)) begin
            r_cfg[i_cfg.index[CFG_SEL_W-1:0]] <= i_cfg.data;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_comb begin
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            mat[k] = r_cfg[k >> 1][(k & 1) * COORD_W +: COORD_W];
        end
    end

    // credit check: queue room for every item already inside the front
    assign i_pt.ready = ({1'b0, q_stat.count} + (QCNT_W+1)'(f_inflight))
                        < (QCNT_W+1)'(QUEUE_DEPTH);

    tpc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_pt.valid && i_pt.ready),
        .i_x        (i_pt.in_x),
        .i_y        (i_pt.in_y),
        .i_z        (i_pt.in_z),
        .i_mat      (mat),
        .o_valid    (f_valid),
        .o_cls      (f_cls),
        .o_neg      (f_neg),
        .o_mag      (f_mag),
        .o_inflight (f_inflight)
    );

    assign q_in = {f_cls, f_neg, f_mag};

    tpc_queue #(.DATA_W(ENTRY_W)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid),
        .i_data   (q_in),
        .i_pop    (pop),
        .o_data   (q_out),
        .o_status (q_stat)
    );

    assign b_mag = q_out[4*S_W-1:0];

    tpc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_stat.empty),
        .i_cls   (t_wclass'(q_out[ENTRY_W-1 -: 2])),
        .i_neg   (q_out[4*S_W +: 4]),
        .i_mag   (b_mag),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ design/tpc_chk.sv @@
// ----------------------------------------------------------------------------
// tpc_chk
// Port-level checks on the result channel of the transform core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_chk import tpc_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               i_ready,
    input wire logic [COORD_W-1:0] i_out_x,
    input wire logic [COORD_W-1:0] i_out_y,
    input wire logic [COORD_W-1:0] i_out_z,
    input wire logic               i_wz,
    input wire logic               i_sat
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_x) && $stable(i_out_y)
                                && $stable(i_out_z))
        else $error("stalled result beat changed");

    a_wzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_wz |-> i_out_x == '0 && i_out_y == '0 && i_out_z == '0 && !i_sat)
        else $error("zero w beat carries data or saturation");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sat |->
            i_out_x == COORD_MAX || i_out_x == COORD_MIN ||
            i_out_y == COORD_MAX || i_out_y == COORD_MIN ||
            i_out_z == COORD_MAX || i_out_z == COORD_MIN)
        else $error("saturation flagged with no clamped coordinate");

endmodule

bind vec3_transform_perspective_core tpc_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_out_x (o_res.out_x),
    .i_out_y (o_res.out_y),
    .i_out_z (o_res.out_z),
    .i_wz    (o_res.w_was_zero),
    .i_sat   (o_res.saturated)
);

`default_nettype wire
